### sv/cse_pkg.sv
package cse_pkg;

  // default sizes
  localparam int DEF_MAX_CHORD_BYTES = 16;
  localparam int DEF_BAR_COUNT_BITS  = 16;

  // field widths
  localparam int BYTE_W = 8;
  localparam int BEAT_W = 20;
  localparam int CFG_W  = 4;

  localparam logic [BEAT_W-1:0] BEAT_MAX = '1;

  // characters of the notation text
  localparam logic [BYTE_W-1:0] CHAR_BAR     = 8'h7C;
  localparam logic [BYTE_W-1:0] CHAR_QUOTE   = 8'h22;
  localparam logic [BYTE_W-1:0] CHAR_NEWLINE = 8'h0A;

  // configuration port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_BEATS_PER_BAR   = 1'b0;
  localparam logic REG_SAME_BEAT_SHIFT = 1'b1;
  localparam logic [CFG_W-1:0] BEATS_PER_BAR_RESET   = 4'd4;
  localparam logic [CFG_W-1:0] SAME_BEAT_SHIFT_RESET = 4'd2;

  typedef enum logic [1:0] {
    PH_LINE_START = 2'd0,
    PH_SKIP_LINE  = 2'd1,
    PH_IN_LINE    = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_BEAT  = 2'd1,
    ST_FETCH = 2'd2,
    ST_SHOW  = 2'd3
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic accept;      // input item taken this cycle
    logic beat;        // finish start beat, read first buffer entry
    logic fetch;       // read next buffer entry
    logic out_accept;  // result item taken this cycle
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic closes;      // incoming byte closes an open chord
    logic last;        // shown result is the final one of the chord
  } stat_t;

endpackage

### sv/cse_ctrl.sv
module cse_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  cse_pkg::stat_t stat_i,
  output cse_pkg::cmd_t  cmd_o
);

  cse_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cse_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      cse_pkg::ST_IDLE: begin
        if (in_valid_i && stat_i.closes) begin
          state_d = cse_pkg::ST_BEAT;
        end
      end
      cse_pkg::ST_BEAT:  state_d = cse_pkg::ST_SHOW;
      cse_pkg::ST_FETCH: state_d = cse_pkg::ST_SHOW;
      cse_pkg::ST_SHOW: begin
        if (out_ready_i) begin
          state_d = stat_i.last ? cse_pkg::ST_IDLE : cse_pkg::ST_FETCH;
        end
      end
      default: state_d = cse_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o       = 1'b0;
    out_valid_o      = 1'b0;
    cmd_o            = '0;
    case (state_q)
      cse_pkg::ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      cse_pkg::ST_BEAT:  cmd_o.beat  = 1'b1;
      cse_pkg::ST_FETCH: cmd_o.fetch = 1'b1;
      cse_pkg::ST_SHOW: begin
        out_valid_o      = 1'b1;
        cmd_o.out_accept = out_ready_i;
      end
      default: ;
    endcase
  end

endmodule

### sv/cse_dp.sv
module cse_dp #(
  parameter int MAX_CHORD_BYTES = cse_pkg::DEF_MAX_CHORD_BYTES,
  parameter int BAR_COUNT_BITS  = cse_pkg::DEF_BAR_COUNT_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cse_pkg::cmd_t                cmd_i,
  output cse_pkg::stat_t               stat_o,
  input  logic [cse_pkg::BYTE_W-1:0]   text_byte_i,
  input  logic                         end_of_text_i,
  input  logic [cse_pkg::CFG_W-1:0]    beats_per_bar_i,
  input  logic [cse_pkg::CFG_W-1:0]    same_beat_shift_i,
  output logic [cse_pkg::BYTE_W-1:0]   chord_byte_o,
  output logic                         byte_valid_o,
  output logic [cse_pkg::BEAT_W-1:0]   start_beat_o,
  output logic                         last_of_chord_o,
  output logic                         chord_truncated_o
);

  localparam int LEN_W  = $clog2(MAX_CHORD_BYTES + 1);
  localparam int IDX_W  = $clog2(MAX_CHORD_BYTES);
  localparam int PROD_W = BAR_COUNT_BITS + cse_pkg::CFG_W;
  localparam int EXT_W  = (PROD_W > cse_pkg::BEAT_W + 1) ? PROD_W : cse_pkg::BEAT_W + 1;
  localparam int SUM_W  = cse_pkg::BEAT_W + 1;

  cse_pkg::phase_e             phase_q, phase_d;
  logic                        inside_q, inside_d;
  logic [BAR_COUNT_BITS-1:0]   bar_q, bar_d;
  logic [LEN_W-1:0]            len_q, len_d;
  logic                        ovf_q, ovf_d;
  logic [cse_pkg::BEAT_W-1:0]  prev_q, prev_d;
  logic                        have_q, have_d;
  logic [cse_pkg::BEAT_W-1:0]  beat_q, beat_d;
  logic                        eot_q, eot_d;
  logic [LEN_W-1:0]            idx_q, idx_d;
  logic [cse_pkg::BYTE_W-1:0]  rd_q;
  logic [cse_pkg::BYTE_W-1:0]  mem [MAX_CHORD_BYTES];

  logic                        wr_en;
  logic [EXT_W-1:0]            prod;
  logic [cse_pkg::BEAT_W-1:0]  beat_raw;
  logic [SUM_W-1:0]            beat_sum;
  logic [cse_pkg::BEAT_W-1:0]  beat_fin;
  logic [LEN_W-1:0]            idx_next;
  logic                        closes;
  logic                        is_bar, is_quote, is_nl;

  assign is_bar   = (text_byte_i == cse_pkg::CHAR_BAR);
  assign is_quote = (text_byte_i == cse_pkg::CHAR_QUOTE);
  assign is_nl    = (text_byte_i == cse_pkg::CHAR_NEWLINE);
  assign closes   = (phase_q == cse_pkg::PH_IN_LINE) && is_quote && inside_q;

  // start beat: bars times beats per bar, saturated
  assign prod     = EXT_W'(bar_q) * EXT_W'(beats_per_bar_i);
  assign beat_raw = (prod > EXT_W'(cse_pkg::BEAT_MAX)) ? cse_pkg::BEAT_MAX
                                                       : prod[cse_pkg::BEAT_W-1:0];

  // shift when landing on the previous chord's beat
  assign beat_sum = {1'b0, beat_q} + SUM_W'(same_beat_shift_i);
  always_comb begin
    beat_fin = beat_q;
    if (have_q && (beat_q == prev_q)) begin
      beat_fin = beat_sum[cse_pkg::BEAT_W] ? cse_pkg::BEAT_MAX
                                           : beat_sum[cse_pkg::BEAT_W-1:0];
    end
  end

  assign idx_next = idx_q + LEN_W'(1);

  assign stat_o.closes = closes;
  assign stat_o.last   = (len_q == '0) || (idx_next == len_q);

  always_comb begin
    phase_d  = phase_q;
    inside_d = inside_q;
    bar_d    = bar_q;
    len_d    = len_q;
    ovf_d    = ovf_q;
    prev_d   = prev_q;
    have_d   = have_q;
    beat_d   = beat_q;
    eot_d    = eot_q;
    idx_d    = idx_q;
    wr_en    = 1'b0;

    if (cmd_i.accept) begin
      case (phase_q)
        cse_pkg::PH_LINE_START: begin
          if (is_bar) begin
            phase_d = cse_pkg::PH_IN_LINE;
          end else if (is_quote) begin
            phase_d  = cse_pkg::PH_IN_LINE;
            inside_d = 1'b1;
            len_d    = '0;
            ovf_d    = 1'b0;
          end else if (!is_nl) begin
            phase_d = cse_pkg::PH_SKIP_LINE;
          end
        end
        cse_pkg::PH_SKIP_LINE: begin
          if (is_nl) begin
            phase_d = cse_pkg::PH_LINE_START;
          end
        end
        default: begin
          if (is_nl) begin
            phase_d  = cse_pkg::PH_LINE_START;
            inside_d = 1'b0;
            len_d    = '0;
            ovf_d    = 1'b0;
          end else begin
            if (is_bar && (bar_q != '1)) begin
              bar_d = bar_q + BAR_COUNT_BITS'(1);
            end
            if (is_quote) begin
              if (inside_q) begin
                // chord stays in the buffer until it has been sent
                inside_d = 1'b0;
                beat_d   = beat_raw;
              end else begin
                inside_d = 1'b1;
                len_d    = '0;
                ovf_d    = 1'b0;
              end
            end else if (inside_q) begin
              if (len_q < LEN_W'(MAX_CHORD_BYTES)) begin
                wr_en = 1'b1;
                len_d = len_q + LEN_W'(1);
              end else begin
                ovf_d = 1'b1;
              end
            end
          end
        end
      endcase

      eot_d = end_of_text_i;
      if (end_of_text_i) begin
        phase_d  = cse_pkg::PH_LINE_START;
        inside_d = 1'b0;
        bar_d    = '0;
        if (!closes) begin
          len_d  = '0;
          ovf_d  = 1'b0;
          prev_d = '0;
          have_d = 1'b0;
        end
      end
    end

    if (cmd_i.beat) begin
      beat_d = beat_fin;
      if (eot_q) begin
        prev_d = '0;
        have_d = 1'b0;
      end else begin
        prev_d = beat_fin;
        have_d = 1'b1;
      end
    end

    if (cmd_i.out_accept) begin
      if (stat_o.last) begin
        idx_d = '0;
        len_d = '0;
        ovf_d = 1'b0;
      end else begin
        idx_d = idx_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= cse_pkg::PH_LINE_START;
      inside_q <= 1'b0;
      bar_q    <= '0;
      len_q    <= '0;
      ovf_q    <= 1'b0;
      prev_q   <= '0;
      have_q   <= 1'b0;
      eot_q    <= 1'b0;
      idx_q    <= '0;
    end else begin
      phase_q  <= phase_d;
      inside_q <= inside_d;
      bar_q    <= bar_d;
      len_q    <= len_d;
      ovf_q    <= ovf_d;
      prev_q   <= prev_d;
      have_q   <= have_d;
      eot_q    <= eot_d;
      idx_q    <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    beat_q <= beat_d;
  end

  // chord buffer
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[len_q[IDX_W-1:0]] <= text_byte_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.beat || cmd_i.fetch) begin
      rd_q <= mem[idx_q[IDX_W-1:0]];
    end
  end

  assign byte_valid_o      = (len_q != '0);
  assign chord_byte_o      = byte_valid_o ? rd_q : '0;
  assign start_beat_o      = beat_q;
  assign last_of_chord_o   = stat_o.last;
  assign chord_truncated_o = ovf_q;

endmodule

### sv/chord_symbol_extractor.sv
// chord symbol extractor: reads notation text one byte per input item; lines
// starting with '|' or '"' are score lines, others are skipped to newline.
// bar marks are counted (saturating) and each quoted chord is collected in a
// MAX_CHORD_BYTES deep buffer; at the closing quote the chord goes out one
// byte per result item with its start beat (bars times beats_per_bar, plus
// same_beat_shift when equal to the previous chord's beat). an empty chord
// gives one item with byte_valid 0; bytes past the buffer are dropped and
// flagged. a byte that does not close a chord needs only its accept step; a
// closing quote is accepted, then a beat step finishes the start beat and
// reads the first buffer entry, then a show step presents the item and waits
// out any output stall; each further item is read from the buffer in a fetch
// step and then shown. the buffer's registered read port sets this read-then-
// show order. no new item is taken while a chord is going out. registers sit
// at byte address 0 (beats_per_bar) and 4 (same_beat_shift), 4 bits each
module chord_symbol_extractor #(
  parameter int MAX_CHORD_BYTES = cse_pkg::DEF_MAX_CHORD_BYTES,
  parameter int BAR_COUNT_BITS  = cse_pkg::DEF_BAR_COUNT_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input channel
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [cse_pkg::BYTE_W-1:0]        text_byte_i,
  input  logic                              end_of_text_i,
  // result channel
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [cse_pkg::BYTE_W-1:0]        chord_byte_o,
  output logic                              byte_valid_o,
  output logic [cse_pkg::BEAT_W-1:0]        start_beat_o,
  output logic                              last_of_chord_o,
  output logic                              chord_truncated_o,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [cse_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [cse_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [cse_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);

  logic [cse_pkg::CFG_W-1:0] bpb_q, bpb_d;
  logic [cse_pkg::CFG_W-1:0] shift_q, shift_d;
  logic                      reg_sel;
  logic                      cfg_wr;

  cse_pkg::cmd_t  cmd;
  cse_pkg::stat_t stat;

  // register index is the word address
  assign reg_sel = paddr[2];
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    bpb_d   = bpb_q;
    shift_d = shift_q;
    if (cfg_wr) begin
      case (reg_sel)
        cse_pkg::REG_BEATS_PER_BAR:   bpb_d   = pwdata[cse_pkg::CFG_W-1:0];
        cse_pkg::REG_SAME_BEAT_SHIFT: shift_d = pwdata[cse_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpb_q   <= cse_pkg::BEATS_PER_BAR_RESET;
      shift_q <= cse_pkg::SAME_BEAT_SHIFT_RESET;
    end else begin
      bpb_q   <= bpb_d;
      shift_q <= shift_d;
    end
  end

  // read back, zero extended
  always_comb begin
    case (reg_sel)
      cse_pkg::REG_BEATS_PER_BAR:   prdata = cse_pkg::APB_DATA_W'(bpb_q);
      cse_pkg::REG_SAME_BEAT_SHIFT: prdata = cse_pkg::APB_DATA_W'(shift_q);
      default:                      prdata = '0;
    endcase
  end

  // sequencing: accept, beat, show, then fetch/show per further chord byte
  cse_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // parser state, chord buffer and beat arithmetic
  cse_dp #(
    .MAX_CHORD_BYTES (MAX_CHORD_BYTES),
    .BAR_COUNT_BITS  (BAR_COUNT_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .text_byte_i       (text_byte_i),
    .end_of_text_i     (end_of_text_i),
    .beats_per_bar_i   (bpb_q),
    .same_beat_shift_i (shift_q),
    .chord_byte_o      (chord_byte_o),
    .byte_valid_o      (byte_valid_o),
    .start_beat_o      (start_beat_o),
    .last_of_chord_o   (last_of_chord_o),
    .chord_truncated_o (chord_truncated_o)
  );

endmodule
